// ----- src/mes_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mes_pkg
// Shared types, element codes and the Morse pattern table.
// ----------------------------------------------------------------------------
package mes_pkg;

  localparam int MaxSyms = 6;
  localparam int CntW    = $clog2(MaxSyms + 1);
  localparam int IdxW    = 6;

  // element kinds
  localparam logic [1:0] KIND_DIT  = 2'd0;
  localparam logic [1:0] KIND_DAH  = 2'd1;
  localparam logic [1:0] KIND_GAP1 = 2'd2;
  localparam logic [1:0] KIND_GAP3 = 2'd3;

  localparam logic [1:0] UNITS_ONE   = 2'd1;
  localparam logic [1:0] UNITS_THREE = 2'd3;

  // character classes and table offsets
  localparam logic [7:0] CASE_FOLD    = 8'd32;
  localparam logic [7:0] LETTER_BASE  = 8'd65;
  localparam logic [7:0] DIGIT_BASE   = 8'd22;
  localparam logic [IdxW-1:0] SYM_QUERY = 6'd36;
  localparam logic [IdxW-1:0] SYM_SLASH = 6'd37;
  localparam logic [IdxW-1:0] SYM_SPACE = 6'd38;

  // symbol pattern: first symbol in bit 0, a set bit is a dash
  typedef struct packed {
    logic                valid;
    logic                word;
    logic [CntW-1:0]     len;
    logic [MaxSyms-1:0]  bits;
  } pat_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [1:0] units;
    logic       last;
  } elem_t;

  function automatic pat_t pattern_lookup(input logic [IdxW-1:0] idx);
    pat_t p;
    p.valid = 1'b1;
    p.word  = 1'b0;
    p.len   = CntW'(0);
    p.bits  = '0;
    unique case (idx)
      6'd0:  begin p.len = 3'd2; p.bits = 6'b000010; end
      6'd1:  begin p.len = 3'd4; p.bits = 6'b000001; end
      6'd2:  begin p.len = 3'd4; p.bits = 6'b000101; end
      6'd3:  begin p.len = 3'd3; p.bits = 6'b000001; end
      6'd4:  begin p.len = 3'd1; p.bits = 6'b000000; end
      6'd5:  begin p.len = 3'd4; p.bits = 6'b000100; end
      6'd6:  begin p.len = 3'd3; p.bits = 6'b000011; end
      6'd7:  begin p.len = 3'd4; p.bits = 6'b000000; end
      6'd8:  begin p.len = 3'd2; p.bits = 6'b000000; end
      6'd9:  begin p.len = 3'd4; p.bits = 6'b001110; end
      6'd10: begin p.len = 3'd3; p.bits = 6'b000101; end
      6'd11: begin p.len = 3'd4; p.bits = 6'b000010; end
      6'd12: begin p.len = 3'd2; p.bits = 6'b000011; end
      6'd13: begin p.len = 3'd2; p.bits = 6'b000001; end
      6'd14: begin p.len = 3'd3; p.bits = 6'b000111; end
      6'd15: begin p.len = 3'd4; p.bits = 6'b000110; end
      6'd16: begin p.len = 3'd4; p.bits = 6'b001011; end
      6'd17: begin p.len = 3'd3; p.bits = 6'b000010; end
      6'd18: begin p.len = 3'd3; p.bits = 6'b000000; end
      6'd19: begin p.len = 3'd1; p.bits = 6'b000001; end
      6'd20: begin p.len = 3'd3; p.bits = 6'b000100; end
      6'd21: begin p.len = 3'd4; p.bits = 6'b001000; end
      6'd22: begin p.len = 3'd3; p.bits = 6'b000110; end
      6'd23: begin p.len = 3'd4; p.bits = 6'b001001; end
      6'd24: begin p.len = 3'd4; p.bits = 6'b001101; end
      6'd25: begin p.len = 3'd4; p.bits = 6'b000011; end
      6'd26: begin p.len = 3'd5; p.bits = 6'b011111; end
      6'd27: begin p.len = 3'd5; p.bits = 6'b011110; end
      6'd28: begin p.len = 3'd5; p.bits = 6'b011100; end
      6'd29: begin p.len = 3'd5; p.bits = 6'b011000; end
      6'd30: begin p.len = 3'd5; p.bits = 6'b010000; end
      6'd31: begin p.len = 3'd5; p.bits = 6'b000000; end
      6'd32: begin p.len = 3'd5; p.bits = 6'b000001; end
      6'd33: begin p.len = 3'd5; p.bits = 6'b000011; end
      6'd34: begin p.len = 3'd5; p.bits = 6'b000111; end
      6'd35: begin p.len = 3'd5; p.bits = 6'b001111; end
      SYM_QUERY: begin p.len = 3'd6; p.bits = 6'b001100; end
      SYM_SLASH: begin p.len = 3'd5; p.bits = 6'b001001; end
      SYM_SPACE: begin p.len = 3'd1; p.word = 1'b1; end
      default: p.valid = 1'b0;
    endcase
    return p;
  endfunction

endpackage

// ----- src/morse_element_sequencer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_element_sequencer
// Turn ASCII bytes into timed Morse tone and gap elements.
// ----------------------------------------------------------------------------
//  channel | dir | ports                        | beat
//  in      | in  | in_tvalid/tready/tdata[7:0]  | one ASCII byte
//  out     | out | out_tvalid/tready/tdata[7:0] | one element, tlast on final
//                  out_tlast
//
//  Flow: each symbol is followed by a one-unit gap and a closing three-unit
//  gap carries tlast; one element leaves per cycle while out_tready is high,
//  the pattern register shifts once per tone; unmapped bytes are dropped.
//  Reset: synchronous, active low; clears the sequencer and the output flag.
//  Stalls: out_tready low holds the output register and the sequencer;
//  in_tready stays low until the sequencer has handed off its last element.
// ----------------------------------------------------------------------------
module morse_element_sequencer (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] char_code
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [1:0] element_kind, [3:2] duration_units, [7:4] zero
  output logic       out_tlast   // last_element
);
  import mes_pkg::*;

  pat_t  pat;
  elem_t elem;
  logic  seq_ready;
  logic  elem_valid;
  logic  elem_ready;
  logic  in_beat;

  logic       out_tvalid_r, out_tvalid_nxt;
  logic [3:0] out_data_r, out_data_nxt;
  logic       out_last_r, out_last_nxt;

  // accept a byte whenever the sequencer is idle; unmapped bytes just drop
  assign in_tready = seq_ready;
  assign in_beat   = in_tvalid && in_tready;

  mes_char_decode u_decode (
    .char_code (in_tdata),
    .pat       (pat)
  );

  mes_element_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (in_beat),
    .pat        (pat),
    .ready      (seq_ready),
    .elem_valid (elem_valid),
    .elem_ready (elem_ready),
    .elem       (elem)
  );

  // output register: refill when empty or when the current beat leaves
  assign elem_ready = !out_tvalid_r || out_tready;

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    out_data_nxt   = out_data_r;
    out_last_nxt   = out_last_r;
    if (elem_ready) begin
      out_tvalid_nxt = elem_valid;
      out_data_nxt   = {elem.units, elem.kind};
      out_last_nxt   = elem.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
    end
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {4'b0000, out_data_r};
  assign out_tlast  = out_last_r;

endmodule

// ----- src/mes_char_decode.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mes_char_decode
// Fold case, map an ASCII byte to a table index and fetch its pattern.
// ----------------------------------------------------------------------------
module mes_char_decode (
  input  logic [7:0]    char_code,
  output mes_pkg::pat_t pat
);
  import mes_pkg::*;

  logic [7:0]      folded;
  logic [IdxW-1:0] idx;

  always_comb begin
    folded = char_code;
    if (char_code >= "a" && char_code <= "z") begin
      folded = char_code - CASE_FOLD;
    end
  end

  always_comb begin
    idx = '1;  // out of table range: no pattern
    if (folded >= "A" && folded <= "Z") begin
      idx = IdxW'(folded - LETTER_BASE);
    end else if (folded >= "0" && folded <= "9") begin
      idx = IdxW'(folded - DIGIT_BASE);
    end else if (folded == "?") begin
      idx = SYM_QUERY;
    end else if (folded == "/") begin
      idx = SYM_SLASH;
    end else if (folded == " ") begin
      idx = SYM_SPACE;
    end
  end

  assign pat = pattern_lookup(idx);

endmodule

// ----- src/mes_element_seq.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mes_element_seq
// Walk a pattern through a shift register, one element per cycle while elem_ready is high.
// ----------------------------------------------------------------------------
module mes_element_seq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  mes_pkg::pat_t pat,
  output logic          ready,
  output logic          elem_valid,
  input  logic          elem_ready,
  output mes_pkg::elem_t elem
);
  import mes_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SYM   = 2'd1;
  localparam logic [1:0] ST_GAP1  = 2'd2;
  localparam logic [1:0] ST_CLOSE = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [MaxSyms-1:0] pat_r, pat_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic               word_r, word_nxt;
  logic               take;

  assign ready      = (state_r == ST_IDLE);
  assign elem_valid = (state_r != ST_IDLE);
  assign take       = elem_valid && elem_ready;

  always_comb begin
    elem = '{kind: KIND_GAP3, units: UNITS_THREE, last: 1'b0};
    unique case (state_r)
      ST_SYM: begin
        if (word_r) begin
          elem.kind  = KIND_GAP3;
          elem.units = UNITS_THREE;
        end else if (pat_r[0]) begin
          elem.kind  = KIND_DAH;
          elem.units = UNITS_THREE;
        end else begin
          elem.kind  = KIND_DIT;
          elem.units = UNITS_ONE;
        end
      end
      ST_GAP1: begin
        elem.kind  = KIND_GAP1;
        elem.units = UNITS_ONE;
      end
      ST_CLOSE: elem.last = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    pat_nxt   = pat_r;
    cnt_nxt   = cnt_r;
    word_nxt  = word_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start && pat.valid) begin
          state_nxt = ST_SYM;
          pat_nxt   = pat.bits;
          cnt_nxt   = pat.len;
          word_nxt  = pat.word;
        end
      end
      ST_SYM: begin
        if (take) begin
          state_nxt = ST_GAP1;
          pat_nxt   = pat_r >> 1;
          cnt_nxt   = cnt_r - CntW'(1);
        end
      end
      ST_GAP1: begin
        if (take) begin
          state_nxt = (cnt_r == '0) ? ST_CLOSE : ST_SYM;
        end
      end
      ST_CLOSE: begin
        if (take) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    pat_r  <= pat_nxt;
    cnt_r  <= cnt_nxt;
    word_r <= word_nxt;
  end

`ifndef SYNTHESIS
  a_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && start && pat.valid) |=> (state_r == ST_SYM))
    else $error("mes_element_seq: mapped character did not start");
  a_sym_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SYM) |-> (cnt_r != '0))
    else $error("mes_element_seq: tone with no symbols left");
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_GAP1 && take && cnt_r == '0) |=> (state_r == ST_CLOSE))
    else $error("mes_element_seq: letter gap skipped");
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> (cnt_r <= CntW'(MaxSyms)))
    else $error("mes_element_seq: symbol count out of range");
`endif

endmodule
